### rtl/itdc_pkg.sv
// Package for the integer to digit characters block: payload types, codes and helpers.
package itdc_pkg;

  localparam int unsigned NumberBitsDefault = 32;
  localparam int unsigned InNumberWidth     = 32;
  localparam int unsigned CountWidth        = 6;
  localparam int unsigned CharWidth         = 7;
  localparam int unsigned DecDigits         = 10;

  localparam logic [CountWidth-1:0] DecMax = 6'd10;
  localparam logic [CountWidth-1:0] HexMax = 6'd8;
  localparam logic [CountWidth-1:0] BinMax = 6'd32;

  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharA     = 7'h41;
  localparam logic [CharWidth-1:0] CharPlus  = 7'h2B;
  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

  typedef enum logic [1:0] {
    FUNC_UDEC = 2'd0,
    FUNC_SDEC = 2'd1,
    FUNC_HEX  = 2'd2,
    FUNC_BIN  = 2'd3
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic [InNumberWidth-1:0]  number;
    logic [CountWidth-1:0]     digit_count;
  } in_t;

  typedef struct packed {
    logic [CharWidth-1:0]  char_code;
    logic [CountWidth-1:0] position;
    logic                  last;
  } out_t;

  // ASCII character for one digit value of 0 to 15.
  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d);
    logic [CharWidth-1:0] ch;
    if (d < 4'd10) begin
      ch = CharZero + CharWidth'(d);
    end else begin
      ch = CharA + CharWidth'(d - 4'd10);
    end
    return ch;
  endfunction

endpackage

### rtl/integer_to_digit_characters.sv
// Top level of the integer to digit characters block: converter and character sequencer.
// A transaction is taken when start is high and busy is low; busy then stays high until
// the last character has been issued. Characters leave one per cycle on out_valid, most
// significant first, and must be taken as they come, since the receiver cannot stall
// them. Decimal modes run one shift-and-add-3 step per bit of the number through a
// single BCD adjust unit, then issue the optional sign, then the digits. Hexadecimal
// and binary need no conversion and go straight to the characters. Only the low
// digits are kept and leading zeros are shown.
module integer_to_digit_characters #(
  parameter int unsigned NUMBER_BITS = itdc_pkg::NumberBitsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  itdc_pkg::in_t   in_data,
  output logic            out_valid,
  output itdc_pkg::out_t  out_data
);

  localparam int unsigned CntWidth = $clog2(NUMBER_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                                  state_r;
  itdc_pkg::func_t                         func_r;
  logic [NUMBER_BITS-1:0]                  val_r;
  logic                                    neg_r;
  logic [itdc_pkg::CountWidth-1:0]         count_r;
  logic [4:0]                              idx_r;
  logic [itdc_pkg::CountWidth-1:0]         pos_r;
  logic [CntWidth-1:0]                     bit_cnt_r;
  logic [3:0]                              bcd_r [itdc_pkg::DecDigits];
  logic                                    out_valid_r;
  itdc_pkg::out_t                          out_data_r;

  logic                                    accept;
  logic [NUMBER_BITS-1:0]                  in_val;
  logic                                    in_neg;
  logic [itdc_pkg::CountWidth-1:0]         limit;
  logic [itdc_pkg::CountWidth-1:0]         count_clamp;
  logic [3:0]                              bcd_adj [itdc_pkg::DecDigits];
  logic [31:0]                             low_word;
  logic [3:0]                              digit;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Input value reduced to NUMBER_BITS bits; in signed mode the magnitude is kept.
  always_comb begin
    in_val = NUMBER_BITS'(in_data.number);
    in_neg = (in_data.func == itdc_pkg::FUNC_SDEC) && in_val[NUMBER_BITS-1];
    if (in_neg) begin
      in_val = -in_val;
    end
    unique case (in_data.func) inside
      itdc_pkg::FUNC_UDEC, itdc_pkg::FUNC_SDEC: limit = itdc_pkg::DecMax;
      itdc_pkg::FUNC_HEX:                       limit = itdc_pkg::HexMax;
      default:                                  limit = itdc_pkg::BinMax;
    endcase
    count_clamp = (in_data.digit_count > limit) ? limit : in_data.digit_count;
  end

  // Shared BCD adjust: every digit of five or more gets three added before the shift.
  // Carries out of the top digit are dropped, which keeps the value modulo ten digits.
  always_comb begin
    for (int i = 0; i < itdc_pkg::DecDigits; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // Digit for the current character.
  always_comb begin
    low_word = 32'(val_r);
    unique case (func_r) inside
      itdc_pkg::FUNC_UDEC, itdc_pkg::FUNC_SDEC: digit = bcd_r[idx_r[3:0]];
      itdc_pkg::FUNC_HEX:  digit = low_word[{idx_r[2:0], 2'b00} +: 4];
      default:             digit = {3'b000, low_word[idx_r]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r    <= in_data.func;
            val_r     <= in_val;
            neg_r     <= in_neg;
            count_r   <= count_clamp;
            idx_r     <= 5'(count_clamp - 6'd1);
            pos_r     <= (in_data.func == itdc_pkg::FUNC_SDEC) ? 6'd1 : 6'd0;
            bit_cnt_r <= CntWidth'(NUMBER_BITS);
            for (int i = 0; i < itdc_pkg::DecDigits; i++) begin
              bcd_r[i] <= 4'd0;
            end
            if (count_clamp == 6'd0) begin
              state_r <= (in_data.func == itdc_pkg::FUNC_SDEC) ? S_SIGN : S_IDLE;
            end else if (in_data.func == itdc_pkg::FUNC_UDEC ||
                         in_data.func == itdc_pkg::FUNC_SDEC) begin
              state_r <= S_CONV;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_CONV: begin
          bcd_r[0] <= {bcd_adj[0][2:0], val_r[NUMBER_BITS-1]};
          for (int i = 1; i < itdc_pkg::DecDigits; i++) begin
            bcd_r[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
          end
          val_r     <= val_r << 1;
          bit_cnt_r <= bit_cnt_r - CntWidth'(1);
          if (bit_cnt_r == CntWidth'(1)) begin
            state_r <= (func_r == itdc_pkg::FUNC_SDEC) ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          out_valid_r          <= 1'b1;
          out_data_r.char_code <= neg_r ? itdc_pkg::CharMinus : itdc_pkg::CharPlus;
          out_data_r.position  <= 6'd0;
          out_data_r.last      <= (count_r == 6'd0);
          state_r              <= (count_r == 6'd0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          out_valid_r          <= 1'b1;
          out_data_r.char_code <= itdc_pkg::digit_char(digit);
          out_data_r.position  <= pos_r;
          out_data_r.last      <= (idx_r == 5'd0);
          idx_r                <= idx_r - 5'd1;
          pos_r                <= pos_r + 6'd1;
          if (idx_r == 5'd0) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("character issued without a transaction in progress");

  a_quiet_conv: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV |-> !out_valid_r)
    else $error("character issued during conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last |-> state_r == S_IDLE)
    else $error("sequencer still busy after the final character");

  a_hex_direct: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.func == itdc_pkg::FUNC_HEX) && (in_data.digit_count != 6'd0)
    |=> state_r == S_EMIT)
    else $error("hexadecimal transaction did not go straight to emission");

endmodule
